/* src/eci_pkg.sv */
// ----------------------------------------------------------------------------
// eci_pkg
// Shared types, codes and fixed-point helpers of the easing curve interpolator.
// ----------------------------------------------------------------------------
package eci_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TW        = FRAC_BITS + 1;          // width of t, w and s
    localparam int VW        = 32;                     // endpoint width
    localparam logic [TW-1:0] ONE  = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);

    // curve mode codes at the port
    localparam logic [3:0] MODE_EASEIN      = 4'd0;
    localparam logic [3:0] MODE_EASEOUT     = 4'd1;
    localparam logic [3:0] MODE_FLAT        = 4'd2;
    localparam logic [3:0] MODE_LINEAR      = 4'd3;
    localparam logic [3:0] MODE_SHARPIN     = 4'd4;
    localparam logic [3:0] MODE_SHARPOUT    = 4'd5;
    localparam logic [3:0] MODE_SHARPSMOOTH = 4'd6;
    localparam logic [3:0] MODE_SMOOTH      = 4'd7;
    localparam logic [3:0] MODE_SOFTIN      = 4'd8;
    localparam logic [3:0] MODE_SOFTOUT     = 4'd9;
    localparam logic [3:0] MODE_SOFTSMOOTH  = 4'd10;

    // curve class after decode
    typedef enum logic [3:0] {
        CRV_ZERO, CRV_FLAT, CRV_LINEAR, CRV_IN4, CRV_OUT4, CRV_IN8, CRV_OUT6,
        CRV_IN2, CRV_OUT2, CRV_SHARPSM, CRV_SMOOTH, CRV_SOFTSM
    } t_curve;

    // classified request passed from front to back
    typedef struct packed {
        t_curve                curve;
        logic                  lo;      // t below one half
        logic [TW-1:0]         t;
        logic [TW-1:0]         w;
        logic signed [VW-1:0]  x0;
        logic signed [VW-1:0]  x1;
    } t_item;

    // rounded unsigned product of two values no larger than one
    function automatic logic [TW-1:0] mulq(input logic [TW-1:0] a,
                                           input logic [TW-1:0] b);
        logic [2*TW-1:0] p;
        p = (2*TW)'(a) * (2*TW)'(b) + (2*TW)'(HALF);
        return p[FRAC_BITS +: TW];
    endfunction

    // (x + 1) >> 1
    function automatic logic [TW-1:0] halfq(input logic [TW-1:0] x);
        logic [TW:0] s;
        s = {1'b0, x} + (TW+1)'(1);
        return s[TW:1];
    endfunction

    // rounded scaled magnitude (mag * s + half) >> frac
    function automatic logic [VW-1:0] rndq(input logic [VW+TW-1:0] p);
        logic [VW+TW-1:0] s;
        s = p + (VW+TW)'(HALF);
        return s[FRAC_BITS +: VW];
    endfunction

    // a plus or minus r
    function automatic logic signed [VW-1:0] applyq(input logic signed [VW-1:0] a,
                                                    input logic neg,
                                                    input logic [VW-1:0] r);
        logic [VW:0] s;
        s = neg ? ({a[VW-1], a} - {1'b0, r}) : ({a[VW-1], a} + {1'b0, r});
        return s[VW-1:0];
    endfunction

endpackage

/* src/eci_front.sv */
// ----------------------------------------------------------------------------
// eci_front
// Accepts requests, saturates phase and weight, and classifies the mode.
// ----------------------------------------------------------------------------
module eci_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [3:0]                   i_curve_mode,
    input  logic signed [eci_pkg::VW-1:0] i_start_value,
    input  logic signed [eci_pkg::VW-1:0] i_end_value,
    input  logic [eci_pkg::TW-1:0]       i_phase,
    input  logic [eci_pkg::TW-1:0]       i_weight,
    input  logic                         i_q_full,
    output logic                         o_hold,
    output logic                         o_push,
    output eci_pkg::t_item               o_item
);

    logic            r_vld;
    eci_pkg::t_item  r_item;
    eci_pkg::t_item  n_item;

    // front register drains whenever the queue has room
    assign o_hold = r_vld && i_q_full;
    assign o_push = r_vld && !i_q_full;
    assign o_item = r_item;

    // classify request
    always_comb begin
        n_item.x0 = i_start_value;
        n_item.x1 = i_end_value;
        n_item.t  = (i_phase  > eci_pkg::ONE) ? eci_pkg::ONE : i_phase;
        n_item.w  = (i_weight > eci_pkg::ONE) ? eci_pkg::ONE : i_weight;
        n_item.lo = n_item.t < eci_pkg::HALF;
        unique case (i_curve_mode)
            eci_pkg::MODE_EASEIN:      n_item.curve = eci_pkg::CRV_IN4;
            eci_pkg::MODE_EASEOUT:     n_item.curve = eci_pkg::CRV_OUT4;
            eci_pkg::MODE_FLAT:        n_item.curve = eci_pkg::CRV_FLAT;
            eci_pkg::MODE_LINEAR:      n_item.curve = eci_pkg::CRV_LINEAR;
            eci_pkg::MODE_SHARPIN:     n_item.curve = eci_pkg::CRV_IN8;
            eci_pkg::MODE_SHARPOUT:    n_item.curve = eci_pkg::CRV_OUT6;
            eci_pkg::MODE_SHARPSMOOTH: n_item.curve = eci_pkg::CRV_SHARPSM;
            eci_pkg::MODE_SMOOTH:      n_item.curve = eci_pkg::CRV_SMOOTH;
            eci_pkg::MODE_SOFTIN:      n_item.curve = eci_pkg::CRV_IN2;
            eci_pkg::MODE_SOFTOUT:     n_item.curve = eci_pkg::CRV_OUT2;
            eci_pkg::MODE_SOFTSMOOTH:  n_item.curve = eci_pkg::CRV_SOFTSM;
            default:                   n_item.curve = eci_pkg::CRV_ZERO;
        endcase
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_take) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= n_item;
        end
    end

endmodule

/* src/eci_queue.sv */
// ----------------------------------------------------------------------------
// eci_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module eci_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  eci_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output eci_pkg::t_item  o_item
);

    eci_pkg::t_item  r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_item  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* src/eci_back.sv */
// ----------------------------------------------------------------------------
// eci_back
// Ten-stage pipeline: easing powers, curve select, eased and linear lerps,
// weight blend.
// ----------------------------------------------------------------------------
module eci_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  eci_pkg::t_item                i_item,
    output logic                          o_vld,
    output logic signed [eci_pkg::VW-1:0] o_value
);

    localparam int TW = eci_pkg::TW;
    localparam int VW = eci_pkg::VW;
    localparam int NS = 9;

    typedef struct packed {
        eci_pkg::t_item   it;
        logic             neg;
        logic [VW-1:0]    mag;
    } t_ctx;

    logic [NS-1:0]        r_v;
    t_ctx                 r_c [NS];
    t_ctx                 n_c0;
    logic [TW-1:0]        r_base, n_base;
    logic [TW-1:0]        r_x2a, r_x2b, r_x2c;
    logic [TW-1:0]        r_x4b, r_x4c;
    logic [TW-1:0]        r_x6, r_x8;
    logic [TW-1:0]        r_s, n_s;
    logic [VW+TW-1:0]     r_pe, r_pl, r_pw;
    logic signed [VW-1:0] r_eased, r_linv, n_eased;
    logic                 r_neg2;
    logic [VW-1:0]        r_mag2;
    logic [VW:0]          n_d2;
    logic [VW:0]          n_d;
    logic                 r_ov;
    logic signed [VW-1:0] r_out;
    logic signed [VW-1:0] r_eased_c, r_linv_c, r_eased_d, r_linv_d;
    logic                 r_neg2_d;

    assign o_vld   = r_ov;
    assign o_value = r_out;

    // stage 0: easing base and endpoint span
    always_comb begin
        n_d        = {i_item.x1[VW-1], i_item.x1} - {i_item.x0[VW-1], i_item.x0};
        n_c0.it    = i_item;
        n_c0.neg   = n_d[VW];
        n_c0.mag   = n_d[VW] ? VW'(-n_d) : n_d[VW-1:0];
        case (i_item.curve) inside
            eci_pkg::CRV_IN4, eci_pkg::CRV_IN8, eci_pkg::CRV_IN2:
                n_base = eci_pkg::ONE - i_item.t;
            eci_pkg::CRV_SHARPSM, eci_pkg::CRV_SMOOTH, eci_pkg::CRV_SOFTSM:
                n_base = i_item.lo ? TW'({i_item.t, 1'b0})
                                   : TW'({eci_pkg::ONE - i_item.t, 1'b0});
            default:
                n_base = i_item.t;
        endcase
    end

    // stage 4: shaped factor
    always_comb begin
        case (r_c[3].it.curve)
            eci_pkg::CRV_LINEAR:  n_s = r_c[3].it.t;
            eci_pkg::CRV_IN4:     n_s = eci_pkg::ONE - r_x4c;
            eci_pkg::CRV_OUT4:    n_s = r_x4c;
            eci_pkg::CRV_IN8:     n_s = eci_pkg::ONE - r_x8;
            eci_pkg::CRV_OUT6:    n_s = r_x6;
            eci_pkg::CRV_IN2:     n_s = eci_pkg::ONE - r_x2c;
            eci_pkg::CRV_OUT2:    n_s = r_x2c;
            eci_pkg::CRV_SHARPSM: n_s = r_c[3].it.lo ? eci_pkg::halfq(r_x2c)
                                        : eci_pkg::ONE - eci_pkg::halfq(r_x6);
            eci_pkg::CRV_SMOOTH:  n_s = r_c[3].it.lo ? eci_pkg::halfq(r_x4c)
                                        : eci_pkg::ONE - eci_pkg::halfq(r_x4c);
            eci_pkg::CRV_SOFTSM:  n_s = r_c[3].it.lo ? eci_pkg::halfq(r_x2c)
                                        : eci_pkg::ONE - eci_pkg::halfq(r_x2c);
            default:              n_s = '0;
        endcase
    end

    // stage 6: eased value, flat picks an endpoint
    always_comb begin
        if (r_c[5].it.curve == eci_pkg::CRV_FLAT) begin
            n_eased = r_c[5].it.t[eci_pkg::FRAC_BITS] ? r_c[5].it.x1 : r_c[5].it.x0;
        end else begin
            n_eased = eci_pkg::applyq(r_c[5].it.x0, r_c[5].neg, eci_pkg::rndq(r_pe));
        end
    end

    assign n_d2 = {r_eased[VW-1], r_eased} - {r_linv[VW-1], r_linv};

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_v  <= {r_v[NS-2:0], i_vld};
            r_ov <= r_v[NS-1];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_c[0] <= n_c0;
        for (int k = 1; k < NS; k++) begin
            r_c[k] <= r_c[k-1];
        end
        r_base  <= n_base;
        r_x2a   <= eci_pkg::mulq(r_base, r_base);
        r_x2b   <= r_x2a;
        r_x4b   <= eci_pkg::mulq(r_x2a, r_x2a);
        r_x2c   <= r_x2b;
        r_x4c   <= r_x4b;
        r_x6    <= eci_pkg::mulq(r_x4b, r_x2b);
        r_x8    <= eci_pkg::mulq(r_x4b, r_x4b);
        r_s     <= n_s;
        r_pe    <= (VW+TW)'(r_c[4].mag) * (VW+TW)'(r_s);
        r_pl    <= (VW+TW)'(r_c[4].mag) * (VW+TW)'(r_c[4].it.t);
        r_eased <= n_eased;
        r_linv  <= eci_pkg::applyq(r_c[5].it.x0, r_c[5].neg, eci_pkg::rndq(r_pl));
        r_neg2  <= n_d2[VW];
        r_mag2  <= n_d2[VW] ? VW'(-n_d2) : n_d2[VW-1:0];
        r_pw    <= (VW+TW)'(r_mag2) * (VW+TW)'(r_c[7].it.w);
        r_out   <= (r_c[8].it.w == eci_pkg::ONE) ? r_eased_d :
                   eci_pkg::applyq(r_linv_d, r_neg2_d, eci_pkg::rndq(r_pw));
    end

    // eased and linear values follow the blend multiply
    always_ff @(posedge i_clk) begin
        r_eased_c <= r_eased;
        r_linv_c  <= r_linv;
        r_eased_d <= r_eased_c;
        r_linv_d  <= r_linv_c;
        r_neg2_d  <= r_neg2;
    end

endmodule

/* src/easing_curve_interpolator_core.sv */
// ----------------------------------------------------------------------------
// easing_curve_interpolator_core
// Eases a phase with one of eleven curves, interpolates between two Q16.16
// endpoints and blends with the linear value by a weight.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  request   | start / busy          | curve_mode, start_value, end_value,
//            |                       | phase, weight
//  result    | o_result_valid strobe | o_result_value
//
//  one request per cycle while busy is low; each result passes the front
//  register, the request queue and the ten-stage back pipeline; busy rises
//  only while the queue is full
//  busy is high during reset; reset clears all valid flags
//  the receiver cannot stall, so the back pipeline never stops
// ----------------------------------------------------------------------------
module easing_curve_interpolator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [3:0]                    i_curve_mode,
    input  logic signed [eci_pkg::VW-1:0] i_start_value,
    input  logic signed [eci_pkg::VW-1:0] i_end_value,
    input  logic [eci_pkg::TW-1:0]        i_phase,
    input  logic [eci_pkg::TW-1:0]        i_weight,
    output logic                          o_result_valid,
    output logic signed [eci_pkg::VW-1:0] o_result_value
);

    logic            hold;
    logic            push;
    logic            q_full;
    logic            q_empty;
    eci_pkg::t_item  f_item;
    eci_pkg::t_item  q_item;

    assign busy = !i_rst_n || hold;

    // front: accept and classify
    eci_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (start && !busy),
        .i_curve_mode  (i_curve_mode),
        .i_start_value (i_start_value),
        .i_end_value   (i_end_value),
        .i_phase       (i_phase),
        .i_weight      (i_weight),
        .i_q_full      (q_full),
        .o_hold        (hold),
        .o_push        (push),
        .o_item        (f_item)
    );

    // request queue
    eci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (!q_empty),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    // back: arithmetic pipeline
    eci_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (!q_empty),
        .i_item  (q_item),
        .o_vld   (o_result_valid),
        .o_value (o_result_value)
    );

endmodule

/* src/eci_checker.sv */
// ----------------------------------------------------------------------------
// eci_checker
// Port-level checks of the easing curve interpolator.
// ----------------------------------------------------------------------------
module eci_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid
);

    // reset flushes every result
    a_rst_flush: assert property (@(posedge i_clk) !i_rst_n |=> !o_result_valid)
        else $error("result strobe after reset");

    // the back end never falls behind, so busy stays low out of reset
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised");

    // each result follows an accepted request
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 12))
        else $error("result without request");

endmodule

bind easing_curve_interpolator_core eci_checker u_eci_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the easing curve interpolator: a directed table of
// requests, then random requests, checked against an in-bench curve predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int N_RANDOM   = 1250;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 40;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [3:0]                    i_curve_mode;
    logic signed [eci_pkg::VW-1:0] i_start_value;
    logic signed [eci_pkg::VW-1:0] i_end_value;
    logic [eci_pkg::TW-1:0]        i_phase;
    logic [eci_pkg::TW-1:0]        i_weight;
    logic                          o_result_valid;
    logic signed [eci_pkg::VW-1:0] o_result_value;

    // one directed row, with an optional typed-in result
    typedef struct {
        logic [3:0]           mode;
        logic signed [31:0]   x0;
        logic signed [31:0]   x1;
        logic [16:0]          t;
        logic [16:0]          w;
        bit                   fixed;
        logic signed [31:0]   value;
    } t_row;

    logic signed [31:0] pending_values[$];
    int                 cycle_count = 0;
    int                 mismatch_count = 0;

    easing_curve_interpolator_core i_dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // rounded fixed-point product
    function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    function automatic longint unsigned fx_half(longint unsigned x);
        return (x + 1) >> 1;
    endfunction

    // interpolate between a and b by s, rounding ties away from zero
    function automatic longint fx_blend(longint a, longint b, longint unsigned s);
        longint          d;
        longint unsigned mag;
        longint unsigned r;
        d   = b - a;
        mag = (d < 0) ? longint'(-d) : d;
        r   = (mag * s + 64'd32768) >> 16;
        return (d < 0) ? a - longint'(r) : a + longint'(r);
    endfunction

    // easing factor for a mode and a saturated phase
    function automatic longint unsigned ease_factor(logic [3:0] mode, longint unsigned t);
        longint unsigned one;
        longint unsigned u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x4;
        one = 64'd65536;
        u   = one - t;
        case (mode)
            eci_pkg::MODE_EASEIN: begin
                x2 = fx_mul(u, u);
                return one - fx_mul(x2, x2);
            end
            eci_pkg::MODE_EASEOUT: begin
                x2 = fx_mul(t, t);
                return fx_mul(x2, x2);
            end
            eci_pkg::MODE_LINEAR: return t;
            eci_pkg::MODE_SHARPIN: begin
                x4 = fx_mul(fx_mul(u, u), fx_mul(u, u));
                return one - fx_mul(x4, x4);
            end
            eci_pkg::MODE_SHARPOUT: begin
                x2 = fx_mul(t, t);
                return fx_mul(fx_mul(x2, x2), x2);
            end
            eci_pkg::MODE_SHARPSMOOTH, eci_pkg::MODE_SMOOTH,
            eci_pkg::MODE_SOFTSMOOTH: begin
                if (t < one / 2) begin
                    x2 = fx_mul(2 * t, 2 * t);
                    if (mode == eci_pkg::MODE_SMOOTH) return fx_half(fx_mul(x2, x2));
                    return fx_half(x2);
                end
                x  = 2 * one - 2 * t;
                x2 = fx_mul(x, x);
                if (mode == eci_pkg::MODE_SOFTSMOOTH) return one - fx_half(x2);
                x4 = fx_mul(x2, x2);
                if (mode == eci_pkg::MODE_SMOOTH) return one - fx_half(x4);
                return one - fx_half(fx_mul(x4, x2));
            end
            eci_pkg::MODE_SOFTIN:  return one - fx_mul(u, u);
            eci_pkg::MODE_SOFTOUT: return fx_mul(t, t);
            default:               return 0;
        endcase
    endfunction

    // full predicted value of one request
    function automatic logic signed [31:0] predict_value(logic [3:0] mode,
            logic signed [31:0] x0, logic signed [31:0] x1, logic [16:0] tin,
            logic [16:0] win);
        longint unsigned t;
        longint unsigned w;
        longint          eased;
        longint          linv;
        t = (tin > 17'd65536) ? 65536 : tin;
        w = (win > 17'd65536) ? 65536 : win;
        if (mode == eci_pkg::MODE_FLAT) eased = (t < 65536) ? longint'(x0) : longint'(x1);
        else eased = fx_blend(x0, x1, ease_factor(mode, t));
        if (w == 65536) return eased[31:0];
        linv = fx_blend(x0, x1, t);
        return 32'(fx_blend(linv, eased, w));
    endfunction

    // result check against the oldest pending value
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_values.size() == 0) begin
                $error("result_value unexpected: actual %0d", o_result_value);
                mismatch_count++;
            end else begin
                if (o_result_value !== pending_values[0]) begin
                    $error("result_value expected %0d actual %0d",
                           pending_values[0], o_result_value);
                    mismatch_count++;
                end
                void'(pending_values.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // issue one request, with a random idle gap ahead of it
    task automatic send_request(logic [3:0] mode, logic signed [31:0] x0,
            logic signed [31:0] x1, logic [16:0] t, logic [16:0] w,
            logic signed [31:0] value);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 9) < 4) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_curve_mode  <= mode;
        i_start_value <= x0;
        i_end_value   <= x1;
        i_phase       <= t;
        i_weight      <= w;
        do @(posedge i_clk); while (busy);
        pending_values.push_back(value);
    endtask

    function automatic logic [16:0] rand_fraction();
        case ($urandom_range(0, 5))
            0:       return 17'($urandom_range(0, 3));
            1:       return 17'($urandom_range(65533, 65536));
            2:       return 17'($urandom_range(65537, 131071));
            3:       return 17'($urandom_range(32766, 32770));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_endpoint();
        case ($urandom_range(0, 4))
            0:       return 32'sh8000_0000 + 32'($urandom_range(0, 3));
            1:       return 32'sh7fff_ffff - 32'($urandom_range(0, 3));
            2:       return 32'($urandom_range(0, 200)) - 32'sd100;
            default: return $urandom();
        endcase
    endfunction

    // directed table and random run
    initial begin
        t_row rows[$];
        t_row r;
        logic [3:0] mode;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic [16:0] t;
        logic [16:0] w;
        int drain;

        start          <= 1'b0;
        i_rst_n        <= 1'b0;
        i_curve_mode   <= eci_pkg::MODE_EASEIN;
        i_start_value  <= '0;
        i_end_value    <= '0;
        i_phase        <= '0;
        i_weight       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // t of zero or one pins every curve to an endpoint
        for (int m = 0; m <= 10; m++) begin
            rows.push_back('{4'(m), -32'sd1000, 32'sd5000, 17'd0, 17'd65536, 1, -32'sd1000});
            rows.push_back('{4'(m), -32'sd1000, 32'sd5000, 17'd65536, 17'd65536, 1, 32'sd5000});
        end
        // unknown mode stays at start; phase and weight saturate above one
        rows.push_back('{4'd15, 32'sd7, 32'sd900, 17'd40000, 17'd131071, 1, 32'sd7});
        rows.push_back('{eci_pkg::MODE_LINEAR, 32'sh8000_0000, 32'sh7fff_ffff, 17'd131071,
                         17'd131071, 1, 32'sh7fff_ffff});
        rows.push_back('{eci_pkg::MODE_SMOOTH, 32'sh7fff_ffff, 32'sh8000_0000, 17'd32768,
                         17'd0, 0, 0});
        rows.push_back('{eci_pkg::MODE_FLAT, 32'sd3, -32'sd3, 17'd65535, 17'd32768, 0, 0});
        rows.push_back('{4'd12, -32'sd50, 32'sd50, 17'd32767, 17'd12345, 0, 0});

        foreach (rows[i]) begin
            r = rows[i];
            send_request(r.mode, r.x0, r.x1, r.t, r.w,
                         r.fixed ? r.value : predict_value(r.mode, r.x0, r.x1, r.t, r.w));
        end

        // random requests, mostly valid modes
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
            x0 = rand_endpoint();
            x1 = rand_endpoint();
            t  = rand_fraction();
            w  = ($urandom_range(0, 3) == 0) ? 17'd65536 : rand_fraction();
            send_request(mode, x0, x1, t, w, predict_value(mode, x0, x1, t, w));
        end
        start <= 1'b0;

        // drain
        drain = 0;
        while (pending_values.size() != 0 && drain < 1000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_values.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (pending_values.size() != 0)
                $error("result_value expected %0d actual none", pending_values[0]);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
src/eci_pkg.sv
src/eci_front.sv
src/eci_queue.sv
src/eci_back.sv
src/easing_curve_interpolator_core.sv
src/eci_checker.sv
sim/tb.sv
